[sv/sun_avoid_arc_position_assert.svh]
// Assertion macros shared by the sun avoidance arc position RTL.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef SUN_AVOID_ARC_POSITION_ASSERT_SVH
`define SUN_AVOID_ARC_POSITION_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define SAP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sap assertion failed");

// The consequent holds in the cycle after the antecedent.
`define SAP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sap assertion failed");

`endif

[sv/sap_pkg.sv]
// Package for the sun avoidance arc position block: widths, latencies, register
// indices, the side struct, angle constants and the CORDIC arctangent table. Depends on nothing.
`timescale 1ns / 1ps
package sap_pkg;

	localparam int AFB        = 16;
	localparam int TIME_WIDTH = 40;
	localparam int FRAC_BITS  = 24;
	localparam int ITERS      = 30;
	localparam int VEC_GUARD  = 12;
	localparam int ROT_GUARD  = 16;

	localparam int CW    = 44;
	localparam int ZW    = 35;
	localparam int AW    = 37;
	localparam int AZD_W = 27;
	localparam int ELD_W = 25;
	localparam int RW    = CW - ROT_GUARD;
	localparam int NW    = 29;

	localparam int VEC_LAT  = ITERS + 2;
	localparam int DIV_LAT  = FRAC_BITS + 2;
	localparam int ROT_LAT  = ITERS + 2;
	localparam int FRAC_PAD = VEC_LAT - DIV_LAT;
	localparam int SB_LEN   = 1 + VEC_LAT + 4 + ROT_LAT;
	localparam int PIPE_LAT = SB_LEN + 3;

	localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [ZW-1:0] TWO_PI_Q30  = 35'sd6746518852;
	localparam logic [29:0]          GAIN_INV    = 30'd652032874;

	localparam logic signed [AZD_W-1:0] HALF_TURN = AZD_W'(180 * (1 << AFB));
	localparam logic signed [AZD_W-1:0] FULL_TURN = AZD_W'(360 * (1 << AFB));
	localparam logic signed [NW-1:0]    FULL_TURN_N = NW'(360 * (1 << AFB));

	typedef enum logic [2:0] {
		REG_RADIUS,
		REG_ENTRY_AZ,
		REG_ENTRY_EL,
		REG_EXIT_AZ,
		REG_EXIT_EL,
		REG_ENTRY_TIME,
		REG_EXIT_TIME,
		REG_GO_CCW
	} reg_idx_t;

	typedef struct packed {
		logic [24:0]        saz;
		logic signed [23:0] sel;
		logic [24:0]        maz;
		logic [22:0]        mel;
	} side_t;

	function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
		logic signed [ZW-1:0] v;
		unique case (i)
			0:  v = 35'sh3243F6A8;
			1:  v = 35'sh1DAC6705;
			2:  v = 35'sh0FADBAFC;
			3:  v = 35'sh07F56EA6;
			4:  v = 35'sh03FEAB76;
			5:  v = 35'sh01FFD55B;
			6:  v = 35'sh00FFFAAA;
			7:  v = 35'sh007FFF55;
			8:  v = 35'sh003FFFEA;
			9:  v = 35'sh001FFFFD;
			10: v = 35'sh000FFFFF;
			11: v = 35'sh0007FFFF;
			12: v = 35'sh0003FFFF;
			13: v = 35'sh0001FFFF;
			14: v = 35'sh0000FFFF;
			15: v = 35'sh00007FFF;
			16: v = 35'sh00003FFF;
			17: v = 35'sh00001FFF;
			18: v = 35'sh00000FFF;
			19: v = 35'sh000007FF;
			20: v = 35'sh000003FF;
			21: v = 35'sh000001FF;
			22: v = 35'sh000000FF;
			23: v = 35'sh0000007F;
			24: v = 35'sh0000003F;
			25: v = 35'sh0000001F;
			26: v = 35'sh0000000F;
			27: v = 35'sh00000008;
			28: v = 35'sh00000004;
			29: v = 35'sh00000002;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[sv/sap_if.sv]
// Item channel interfaces for the sun avoidance arc position block.
// Depends on nothing but the port widths of the block.
`timescale 1ns / 1ps
interface sap_pos_if;
	logic               valid;
	logic               ready;
	logic [39:0]        sample_time;
	logic [24:0]        sun_az;
	logic signed [23:0] sun_el;
	logic [24:0]        mount_az;
	logic [22:0]        mount_el;

	modport source (output valid, sample_time, sun_az, sun_el, mount_az, mount_el,
		input ready);
	modport sink (input valid, sample_time, sun_az, sun_el, mount_az, mount_el,
		output ready);
endinterface

interface sap_res_if;
	logic               valid;
	logic               ready;
	logic [24:0]        new_az;
	logic signed [24:0] new_el;
	logic signed [25:0] delta_az;
	logic signed [25:0] delta_el;

	modport source (output valid, new_az, new_el, delta_az, delta_el, input ready);
	modport sink (input valid, new_az, new_el, delta_az, delta_el, output ready);
endinterface

[sv/sun_avoid_arc_position.sv]
// Sun avoidance arc position: maps a mount sample onto the avoidance circle.
// One item per cycle while the output is not stalled; the whole pipeline holds
// only on output stall. Two 30-stage vectoring CORDICs and a 30-stage rotation
// CORDIC set the depth; the 24-stage divider runs beside them, padded to match.
// Reset clears the valid bits and loads the register reset values.
// Depends on sap_pkg, sap_if, sap_vec, sap_div, sap_rot and the assertion header.
`timescale 1ns / 1ps
`include "sun_avoid_arc_position_assert.svh"
module sun_avoid_arc_position (
	input  logic        clk,
	input  logic        arst_n,
	sap_pos_if.sink     pos,
	sap_res_if.source   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	localparam int TW = sap_pkg::TIME_WIDTH;
	localparam int ZW = sap_pkg::ZW;
	localparam int AW = sap_pkg::AW;
	localparam int NW = sap_pkg::NW;
	localparam int FB = sap_pkg::FRAC_BITS;
	localparam int FL = 13;
	localparam int FH = FB + 1 - FL;
	localparam int PW = ZW + FB + 1;
	localparam logic signed [AW-1:0] PI_AW = AW'(sap_pkg::PI_Q30);

	logic [22:0]   radius_q;
	logic [24:0]   entry_az_q;
	logic [22:0]   entry_el_q;
	logic [24:0]   exit_az_q;
	logic [22:0]   exit_el_q;
	logic [TW-1:0] entry_time_q;
	logic [TW-1:0] exit_time_q;
	logic          go_ccw_q;
	logic          wr;
	sap_pkg::reg_idx_t idx;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = sap_pkg::reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q     <= 23'd983040;
			entry_az_q   <= '0;
			entry_el_q   <= '0;
			exit_az_q    <= '0;
			exit_el_q    <= '0;
			entry_time_q <= '0;
			exit_time_q  <= '0;
			go_ccw_q     <= 1'b0;
		end else if (wr) begin
			unique case (idx)
				sap_pkg::REG_RADIUS:     radius_q     <= pwdata[22:0];
				sap_pkg::REG_ENTRY_AZ:   entry_az_q   <= pwdata[24:0];
				sap_pkg::REG_ENTRY_EL:   entry_el_q   <= pwdata[22:0];
				sap_pkg::REG_EXIT_AZ:    exit_az_q    <= pwdata[24:0];
				sap_pkg::REG_EXIT_EL:    exit_el_q    <= pwdata[22:0];
				sap_pkg::REG_ENTRY_TIME: entry_time_q <= pwdata[TW-1:0];
				sap_pkg::REG_EXIT_TIME:  exit_time_q  <= pwdata[TW-1:0];
				sap_pkg::REG_GO_CCW:     go_ccw_q     <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			sap_pkg::REG_RADIUS:     prdata = 64'(radius_q);
			sap_pkg::REG_ENTRY_AZ:   prdata = 64'(entry_az_q);
			sap_pkg::REG_ENTRY_EL:   prdata = 64'(entry_el_q);
			sap_pkg::REG_EXIT_AZ:    prdata = 64'(exit_az_q);
			sap_pkg::REG_EXIT_EL:    prdata = 64'(exit_el_q);
			sap_pkg::REG_ENTRY_TIME: prdata = 64'(entry_time_q);
			sap_pkg::REG_EXIT_TIME:  prdata = 64'(exit_time_q);
			sap_pkg::REG_GO_CCW:     prdata = 64'(go_ccw_q);
		endcase
	end

	// Pipeline control: every stage advances unless the result is stalled.
	logic [sap_pkg::PIPE_LAT-1:0] vld_s;
	logic en;

	assign en = !vld_s[sap_pkg::PIPE_LAT-1] || res.ready;
	assign pos.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[sap_pkg::PIPE_LAT-2:0], pos.valid};
		end
	end

	// Stage 1: azimuth wrap, elevation offsets and time differences.
	function automatic logic signed [sap_pkg::AZD_W-1:0] wrap_half(input logic [24:0] a,
		input logic [24:0] b);
		logic signed [sap_pkg::AZD_W-1:0] d;
		d = $signed({2'b00, a}) - $signed({2'b00, b});
		if (d > sap_pkg::HALF_TURN) begin
			return d - sap_pkg::FULL_TURN;
		end else if (d < -sap_pkg::HALF_TURN) begin
			return d + sap_pkg::FULL_TURN;
		end
		return d;
	endfunction

	logic signed [sap_pkg::AZD_W-1:0] ex_s1, xx_s1;
	logic signed [sap_pkg::ELD_W-1:0] ey_s1, xy_s1;
	logic [TW-1:0] n_s1, d_s1;
	logic          nneg_s1, dneg_s1;
	sap_pkg::side_t sb_s [0:sap_pkg::SB_LEN-1];
	logic signed [sap_pkg::ELD_W-1:0] sel_ext;

	assign sel_ext = {pos.sun_el[23], pos.sun_el};

	always_ff @(posedge clk) begin
		if (en) begin
			ex_s1   <= wrap_half(entry_az_q, pos.sun_az);
			xx_s1   <= wrap_half(exit_az_q, pos.sun_az);
			ey_s1   <= $signed({2'b00, entry_el_q}) - sel_ext;
			xy_s1   <= $signed({2'b00, exit_el_q}) - sel_ext;
			nneg_s1 <= pos.sample_time >= entry_time_q;
			n_s1    <= (pos.sample_time >= entry_time_q) ? pos.sample_time - entry_time_q
				: entry_time_q - pos.sample_time;
			dneg_s1 <= exit_time_q < entry_time_q;
			d_s1    <= (exit_time_q < entry_time_q) ? entry_time_q - exit_time_q
				: exit_time_q - entry_time_q;
			sb_s[0] <= '{saz: pos.sun_az, sel: pos.sun_el, maz: pos.mount_az,
				mel: pos.mount_el};
		end
	end

	for (genvar k = 1; k < sap_pkg::SB_LEN; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[k] <= sb_s[k-1];
			end
		end
	end

	logic [ZW-1:0] e_ang, x_ang;
	logic [FB:0]   div_frac;
	logic [FB:0]   fp_s [0:sap_pkg::FRAC_PAD-1];

	sap_vec u_vec_entry (.clk(clk), .en(en), .x_in(ex_s1), .y_in(ey_s1), .ang(e_ang));
	sap_vec u_vec_exit (.clk(clk), .en(en), .x_in(xx_s1), .y_in(xy_s1), .ang(x_ang));
	sap_div u_div (.clk(clk), .en(en), .n_in(n_s1), .d_in(d_s1), .nneg(nneg_s1),
		.dneg(dneg_s1), .frac(div_frac));

	always_ff @(posedge clk) begin
		if (en) begin
			fp_s[0] <= div_frac;
		end
	end

	for (genvar k = 1; k < sap_pkg::FRAC_PAD; k++) begin : g_fpad
		always_ff @(posedge clk) begin
			if (en) begin
				fp_s[k] <= fp_s[k-1];
			end
		end
	end

	// Arc, interpolation and range reduction.
	logic signed [ZW-1:0]      arc_raw;
	logic signed [ZW-1:0]      arc_s34;
	logic [FB:0]               frac_s34;
	logic [ZW-1:0]             eang_s34, eang_s35;
	logic signed [ZW+FL:0]     pl_s35;
	logic signed [ZW+FH:0]     ph_s35;
	logic signed [PW-1:0]      prod;
	logic signed [AW-1:0]      ang_s36;
	logic signed [ZW-1:0]      red_s37;

	assign arc_raw = $signed(x_ang) - $signed(e_ang);
	assign prod = PW'(pl_s35) + (PW'(ph_s35) <<< FL);

	always_ff @(posedge clk) begin
		if (en) begin
			if (arc_raw > 0) begin
				arc_s34 <= go_ccw_q ? arc_raw - sap_pkg::TWO_PI_Q30 : arc_raw;
			end else begin
				arc_s34 <= go_ccw_q ? arc_raw : arc_raw + sap_pkg::TWO_PI_Q30;
			end
			frac_s34 <= fp_s[sap_pkg::FRAC_PAD-1];
			eang_s34 <= e_ang;

			pl_s35   <= arc_s34 * $signed({1'b0, frac_s34[FL-1:0]});
			ph_s35   <= arc_s34 * $signed({1'b0, frac_s34[FB:FL]});
			eang_s35 <= eang_s34;

			ang_s36 <= $signed({2'b00, eang_s35}) + AW'($signed(prod[PW-1:FB]));

			if (ang_s36 > 3 * PI_AW) begin
				red_s37 <= ZW'(ang_s36 - 4 * PI_AW);
			end else if (ang_s36 > PI_AW) begin
				red_s37 <= ZW'(ang_s36 - 2 * PI_AW);
			end else if (ang_s36 < -PI_AW) begin
				red_s37 <= ZW'(ang_s36 + 2 * PI_AW);
			end else begin
				red_s37 <= ZW'(ang_s36);
			end
		end
	end

	logic signed [sap_pkg::RW-1:0] cos_v, sin_v;

	sap_rot u_rot (.clk(clk), .en(en), .a_in(red_s37), .radius(radius_q),
		.cos_out(cos_v), .sin_out(sin_v));

	// Output stages: sum, azimuth wrap, differences.
	sap_pkg::side_t       side;
	logic signed [NW-1:0] naz_s70, nel_s70, naz_s71, nel_s71, daz, del;
	logic [24:0]          maz_s70, maz_s71;
	logic [22:0]          mel_s70, mel_s71;
	logic [24:0]          new_az_s72;
	logic signed [24:0]   new_el_s72;
	logic signed [25:0]   delta_az_s72, delta_el_s72;

	assign side = sb_s[sap_pkg::SB_LEN-1];
	assign daz = naz_s71 - $signed({4'b0000, maz_s71});
	assign del = nel_s71 - $signed({6'b000000, mel_s71});

	always_ff @(posedge clk) begin
		if (en) begin
			naz_s70 <= $signed({4'b0000, side.saz}) + NW'(cos_v);
			nel_s70 <= NW'(side.sel) + NW'(sin_v);
			maz_s70 <= side.maz;
			mel_s70 <= side.mel;

			if (naz_s70 < 0) begin
				naz_s71 <= naz_s70 + sap_pkg::FULL_TURN_N;
			end else if (naz_s70 > sap_pkg::FULL_TURN_N) begin
				naz_s71 <= naz_s70 - sap_pkg::FULL_TURN_N;
			end else begin
				naz_s71 <= naz_s70;
			end
			nel_s71 <= nel_s70;
			maz_s71 <= maz_s70;
			mel_s71 <= mel_s70;

			new_az_s72   <= naz_s71[24:0];
			new_el_s72   <= nel_s71[24:0];
			delta_az_s72 <= daz[25:0];
			delta_el_s72 <= del[25:0];
		end
	end

	assign res.valid    = vld_s[sap_pkg::PIPE_LAT-1];
	assign res.new_az   = new_az_s72;
	assign res.new_el   = new_el_s72;
	assign res.delta_az = delta_az_s72;
	assign res.delta_el = delta_el_s72;

	`SAP_ASSERT_NOW(a_stall_only_on_hold, !pos.ready, res.valid && !res.ready)
	`SAP_ASSERT_NEXT(a_accept_enters, pos.valid && pos.ready, vld_s[0])
	`SAP_ASSERT_NEXT(a_hold_freezes, res.valid && !res.ready, $stable(vld_s))
endmodule

[sv/sap_vec.sv]
// Pipelined vectoring CORDIC: angle of an (x, y) offset in Q30 radians, 0..2pi.
// Depends on sap_pkg.
`timescale 1ns / 1ps
module sap_vec (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [sap_pkg::AZD_W-1:0] x_in,
	input  logic signed [sap_pkg::ELD_W-1:0] y_in,
	output logic [sap_pkg::ZW-1:0]            ang
);
	logic signed [sap_pkg::CW-1:0] x_s [0:sap_pkg::ITERS];
	logic signed [sap_pkg::CW-1:0] y_s [0:sap_pkg::ITERS];
	logic signed [sap_pkg::ZW-1:0] z_s [0:sap_pkg::ITERS];
	logic                          zero_s [0:sap_pkg::ITERS];
	logic [sap_pkg::ZW-1:0]        ang_s;
	logic signed [sap_pkg::CW-1:0] xs, ys;

	assign xs = {{(sap_pkg::CW - sap_pkg::AZD_W - sap_pkg::VEC_GUARD){x_in[sap_pkg::AZD_W-1]}},
		x_in, {sap_pkg::VEC_GUARD{1'b0}}};
	assign ys = {{(sap_pkg::CW - sap_pkg::ELD_W - sap_pkg::VEC_GUARD){y_in[sap_pkg::ELD_W-1]}},
		y_in, {sap_pkg::VEC_GUARD{1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (xs < 0) begin
				if (ys >= 0) begin
					x_s[0] <= ys;
					y_s[0] <= -xs;
					z_s[0] <= sap_pkg::HALF_PI_Q30;
				end else begin
					x_s[0] <= -ys;
					y_s[0] <= xs;
					z_s[0] <= -sap_pkg::HALF_PI_Q30;
				end
			end else begin
				x_s[0] <= xs;
				y_s[0] <= ys;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < sap_pkg::ITERS; i++) begin : g_iter
		logic signed [sap_pkg::CW-1:0] dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + sap_pkg::atan_q30(i);
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - sap_pkg::atan_q30(i);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[sap_pkg::ITERS]) begin
				ang_s <= '0;
			end else if (z_s[sap_pkg::ITERS] < 0) begin
				ang_s <= z_s[sap_pkg::ITERS] + sap_pkg::TWO_PI_Q30;
			end else begin
				ang_s <= z_s[sap_pkg::ITERS];
			end
		end
	end

	assign ang = ang_s;
endmodule

[sv/sap_div.sv]
// Pipelined restoring divider for the time fraction, 24 quotient bits,
// saturated to 0..1. Depends on sap_pkg.
`timescale 1ns / 1ps
module sap_div (
	input  logic                             clk,
	input  logic                             en,
	input  logic [sap_pkg::TIME_WIDTH-1:0]   n_in,
	input  logic [sap_pkg::TIME_WIDTH-1:0]   d_in,
	input  logic                             nneg,
	input  logic                             dneg,
	output logic [sap_pkg::FRAC_BITS:0]      frac
);
	localparam int TW = sap_pkg::TIME_WIDTH;
	localparam int FB = sap_pkg::FRAC_BITS;

	logic [TW-1:0] r_s [0:FB];
	logic [TW-1:0] d_s [0:FB];
	logic [FB-1:0] q_s [0:FB];
	logic          zero_s [0:FB];
	logic          one_s [0:FB];
	logic [FB:0]   frac_s;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]    <= n_in;
			d_s[0]    <= d_in;
			q_s[0]    <= '0;
			zero_s[0] <= (d_in == '0) || (n_in == '0) || (nneg == dneg);
			one_s[0]  <= n_in >= d_in;
		end
	end

	for (genvar i = 0; i < FB; i++) begin : g_step
		logic [TW:0] r2;
		assign r2 = {r_s[i], 1'b0};
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[i+1]    <= d_s[i];
				zero_s[i+1] <= zero_s[i];
				one_s[i+1]  <= one_s[i];
				if (r2 >= {1'b0, d_s[i]}) begin
					r_s[i+1] <= TW'(r2 - {1'b0, d_s[i]});
					q_s[i+1] <= {q_s[i][FB-2:0], 1'b1};
				end else begin
					r_s[i+1] <= r2[TW-1:0];
					q_s[i+1] <= {q_s[i][FB-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[FB]) begin
				frac_s <= '0;
			end else if (one_s[FB]) begin
				frac_s <= {1'b1, {FB{1'b0}}};
			end else begin
				frac_s <= {1'b0, q_s[FB]};
			end
		end
	end

	assign frac = frac_s;
endmodule

[sv/sap_rot.sv]
// Pipelined rotation CORDIC: point of radius r at an angle in -pi..pi,
// rounded to whole output units. Depends on sap_pkg.
`timescale 1ns / 1ps
module sap_rot (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [sap_pkg::ZW-1:0]  a_in,
	input  logic [22:0]                    radius,
	output logic signed [sap_pkg::RW-1:0]  cos_out,
	output logic signed [sap_pkg::RW-1:0]  sin_out
);
	localparam int CW = sap_pkg::CW;
	localparam int RG = sap_pkg::ROT_GUARD;

	logic signed [CW-1:0]          x_s [0:sap_pkg::ITERS];
	logic signed [CW-1:0]          y_s [0:sap_pkg::ITERS];
	logic signed [sap_pkg::ZW-1:0] a_s [0:sap_pkg::ITERS];
	logic                          neg_s [0:sap_pkg::ITERS];
	logic signed [sap_pkg::RW-1:0] cos_s, sin_s;
	logic [52:0]                   gain_prod;
	logic signed [CW-1:0]          half, xp, xn, yp, yn;

	assign gain_prod = 53'(radius) * 53'(sap_pkg::GAIN_INV);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CW'(gain_prod[52:30-RG]);
			y_s[0] <= '0;
			if (a_in > sap_pkg::HALF_PI_Q30) begin
				a_s[0]   <= a_in - sap_pkg::PI_Q30;
				neg_s[0] <= 1'b1;
			end else if (a_in < -sap_pkg::HALF_PI_Q30) begin
				a_s[0]   <= a_in + sap_pkg::PI_Q30;
				neg_s[0] <= 1'b1;
			end else begin
				a_s[0]   <= a_in;
				neg_s[0] <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < sap_pkg::ITERS; i++) begin : g_iter
		logic signed [CW-1:0] dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[i+1] <= neg_s[i];
				if (a_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					a_s[i+1] <= a_s[i] - sap_pkg::atan_q30(i);
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					a_s[i+1] <= a_s[i] + sap_pkg::atan_q30(i);
				end
			end
		end
	end

	assign half = CW'(1) <<< (RG - 1);
	assign xp = x_s[sap_pkg::ITERS] + half;
	assign xn = half - x_s[sap_pkg::ITERS];
	assign yp = y_s[sap_pkg::ITERS] + half;
	assign yn = half - y_s[sap_pkg::ITERS];

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[sap_pkg::ITERS]) begin
				cos_s <= xn[CW-1:RG];
				sin_s <= yn[CW-1:RG];
			end else begin
				cos_s <= xp[CW-1:RG];
				sin_s <= yp[CW-1:RG];
			end
		end
	end

	assign cos_out = cos_s;
	assign sin_out = sin_s;
endmodule
